@@ rtl/bottom_up_merge_sorter_top_macros.svh @@
// Assertion macros shared by the sorter RTL.
// Included by the files that check their own logic; no other dependencies.
`ifndef BOTTOM_UP_MERGE_SORTER_TOP_MACROS_SVH
`define BOTTOM_UP_MERGE_SORTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent holds in this cycle, consequent in the same cycle.
`define BUMSORT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sorter assertion failed");
// Antecedent holds in this cycle, consequent in the next one.
`define BUMSORT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sorter assertion failed");
`else
`define BUMSORT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BUMSORT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/bumsort_pkg.sv @@
// Shared constants and types of the sorter.
// No dependencies; used by the interfaces, the cell row and the top level.
package bumsort_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // One element slot: occupancy flag and the signed value it carries.
    typedef struct packed {
        logic                     vld;
        logic signed [DATA_W-1:0] val;
    } slot_t;

endpackage

@@ rtl/bumsort_in_if.sv @@
// Element input channel: valid/ready handshake with value and last flag.
// Depends on bumsort_pkg for the data width.
interface bumsort_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bumsort_pkg::DATA_W-1:0] value;
    logic                                 last_in;

    modport source (output valid, output value, output last_in, input ready);
    modport sink   (input valid, input value, input last_in, output ready);
endinterface

@@ rtl/bumsort_out_if.sv @@
// Sorted output channel: valid/ready handshake with value and last flag.
// Depends on bumsort_pkg for the data width.
interface bumsort_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bumsort_pkg::DATA_W-1:0] sorted_value;
    logic                                 last_out;

    modport source (output valid, output sorted_value, output last_out, input ready);
    modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

@@ rtl/bottom_up_merge_sorter_top.sv @@
// Sorter for sets of up to DEPTH (64) signed 32-bit values. Load a set one
// value per transaction on "items"; the transaction flagged last_in, or the
// one that fills the last free place, closes the set. The block answers with
// the values in ascending order on "sorted", one transaction each, with
// last_out on the final one. A set passes through loading, then a settle
// wait while the last insertions ripple down the row of cells, then
// emitting, where the sink may stall. The cell row is the limit: a value
// moves one cell per cycle while loading and, unless the sink stalls, one
// cell per cycle toward the head while emitting. New values are taken only
// while loading; once the final value of a set leaves, the block is ready
// for the next set at once. No clearing pass is needed after reset: the
// cell occupancy flags reset to empty.
// Depends on bumsort_pkg, the channel interfaces, bumsort_chain and the
// assertion macro header.
`include "bottom_up_merge_sorter_top_macros.svh"
module bottom_up_merge_sorter_top (
    input  logic          clk,
    input  logic          rst_n,
    bumsort_in_if.sink    items,
    bumsort_out_if.source sorted
);
    import bumsort_pkg::*;

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;   // elements in the current set
    logic [CNT_W-1:0] drain_reg, drain_next;   // settle cycles still to wait

    logic  in_take;
    logic  out_take;
    logic  close_set;
    slot_t insert;
    slot_t head;

    assign items.ready = (state_reg == ST_LOAD);
    assign in_take     = items.valid && items.ready;
    assign close_set   = in_take && (items.last_in || count_reg == CNT_W'(DEPTH - 1));

    // an accepted value enters the head cell in the same edge
    assign insert.vld = in_take;
    assign insert.val = items.value;

    assign sorted.valid        = (state_reg == ST_EMIT);
    assign sorted.sorted_value = head.val;
    assign sorted.last_out     = (count_reg == CNT_W'(1));
    assign out_take            = sorted.valid && sorted.ready;

    bumsort_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .insert (insert),
        .shift  (out_take),
        .head   (head)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        drain_next = drain_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_take)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (close_set)
                begin
                    // arm the settle counter; the last insertion settles before it runs
                    // out
                    drain_next = count_reg + CNT_W'(1);
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg - CNT_W'(1);
                if (drain_reg == CNT_W'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_take)
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
                count_next = '0;
                drain_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drain_reg <= drain_next;
        end
    end

    // a closing transaction always leads to the settle phase
    `BUMSORT_ASSERT_NXT(a_close_drain, clk, rst_n, close_set, state_reg == ST_DRAIN)
    // the final output transaction empties the set and reopens loading
    `BUMSORT_ASSERT_NXT(a_last_reload, clk, rst_n, out_take && sorted.last_out,
                        state_reg == ST_LOAD && count_reg == '0)
    // while emitting, the set is never empty
    `BUMSORT_ASSERT_IMP(a_emit_nonempty, clk, rst_n, state_reg == ST_EMIT, count_reg != '0)
    // no loading and emitting at the same time
    `BUMSORT_ASSERT_IMP(a_one_side, clk, rst_n, items.ready, !sorted.valid)

endmodule

@@ rtl/bumsort_cell.sv @@
// One sorting cell: holds one element, keeps the smaller of held and arriving.
// Depends on bumsort_pkg.
module bumsort_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  bumsort_pkg::slot_t  pass_in,
    input  bumsort_pkg::slot_t  from_right,
    output bumsort_pkg::slot_t  pass_out,
    output bumsort_pkg::slot_t  held
);
    import bumsort_pkg::*;

    logic                     held_vld_reg, held_vld_next;
    logic signed [DATA_W-1:0] held_val_reg, held_val_next;
    logic                     pass_vld_reg, pass_vld_next;
    logic signed [DATA_W-1:0] pass_val_reg, pass_val_next;

    always_comb
    begin
        held_vld_next = held_vld_reg;
        held_val_next = held_val_reg;
        pass_vld_next = 1'b0;
        pass_val_next = pass_val_reg;
        if (shift)
        begin
            // advance one place toward the head
            held_vld_next = from_right.vld;
            held_val_next = from_right.val;
        end
        else if (pass_in.vld)
        begin
            if (!held_vld_reg)
            begin
                held_vld_next = 1'b1;
                held_val_next = pass_in.val;
            end
            else if (pass_in.val < held_val_reg)
            begin
                // keep the smaller, push the held one on
                held_val_next = pass_in.val;
                pass_vld_next = 1'b1;
                pass_val_next = held_val_reg;
            end
            else
            begin
                pass_vld_next = 1'b1;
                pass_val_next = pass_in.val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_vld_reg <= 1'b0;
            pass_vld_reg <= 1'b0;
        end
        else
        begin
            held_vld_reg <= held_vld_next;
            pass_vld_reg <= pass_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_val_reg <= held_val_next;
        pass_val_reg <= pass_val_next;
    end

    assign held.vld     = held_vld_reg;
    assign held.val     = held_val_reg;
    assign pass_out.vld = pass_vld_reg;
    assign pass_out.val = pass_val_reg;

endmodule

@@ rtl/bumsort_chain.sv @@
// Row of sorting cells; elements enter at the head and leave from the head.
// Depends on bumsort_pkg, bumsort_cell and the assertion macro header.
`include "bottom_up_merge_sorter_top_macros.svh"
module bumsort_chain (
    input  logic                clk,
    input  logic                rst_n,
    input  bumsort_pkg::slot_t  insert,
    input  logic                shift,
    output bumsort_pkg::slot_t  head
);
    import bumsort_pkg::*;

    slot_t pass [DEPTH+1];
    slot_t held [DEPTH+1];

    assign pass[0]    = insert;
    assign held[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        bumsort_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (shift),
            .pass_in    (pass[i]),
            .from_right (held[i+1]),
            .pass_out   (pass[i+1]),
            .held       (held[i])
        );
    end

    assign head = held[0];

    // the row never overflows: a set holds at most DEPTH elements
    `BUMSORT_ASSERT_IMP(a_no_overflow, clk, rst_n, 1'b1, !pass[DEPTH].vld)
    // shifting only happens with a settled row and an occupied head
    `BUMSORT_ASSERT_IMP(a_shift_head, clk, rst_n, shift, held[0].vld)
    `BUMSORT_ASSERT_IMP(a_shift_settled, clk, rst_n, shift, !pass[1].vld && !insert.vld)

endmodule

@@ dv/bottom_up_merge_sorter_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for bottom_up_merge_sorter_top: load sets, predict the ascending output.
// Depends on bumsort_pkg, bumsort_in_if, bumsort_out_if and the sorter RTL.
module bottom_up_merge_sorter_top_tb;
    import bumsort_pkg::*;

    // Watchdog limit in cycles, and the quiet time after the final result.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4 * DEPTH + 20;
    // Loads in this window run with no random idling on either side.
    localparam int CALM_FROM    = 150;
    localparam int CALM_TO      = 280;
    localparam int RANDOM_LOADS = 460;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // One pending load; hold makes the sender wait until all results are in.
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        bit                       hold;
    } load_t;

    // One expected sorted element.
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } sorted_t;

    logic clk = 1'b0;
    logic rst_n;

    bumsort_in_if  items_ch ();
    bumsort_out_if sorted_ch ();

    bottom_up_merge_sorter_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (items_ch),
        .sorted (sorted_ch)
    );

    load_t   pending_loads[$];
    sorted_t expected_sorted[$];

    // Shadow of the element store for the set being loaded.
    logic signed [DATA_W-1:0] set_store[DEPTH];
    logic signed [DATA_W-1:0] set_scratch[DEPTH];
    int                       set_fill = 0;

    int results_outstanding = 0;
    int loads_accepted      = 0;
    int mismatches          = 0;
    int cycle_count         = 0;

    always #6 clk = ~clk;

    // Hold reset, then release it away from the rising edge.
    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Sort the current set by bottom-up merging (runs double from one, left run
    // wins ties), queue the sorted elements with last on the final one, and
    // empty the shadow store.
    task automatic sort_and_queue();
        int width;
        int lo;
        int mid;
        int hi;
        int i;
        int j;
        int k;
        for (width = 1; width < set_fill; width = width * 2)
        begin
            for (lo = 0; lo + width < set_fill; lo = lo + 2 * width)
            begin
                mid = lo + width;
                hi  = (lo + 2 * width > set_fill) ? set_fill : lo + 2 * width;
                i   = lo;
                j   = mid;
                k   = lo;
                while (i < mid && j < hi)
                begin
                    if (set_store[i] <= set_store[j])
                    begin
                        set_scratch[k] = set_store[i];
                        i++;
                    end
                    else
                    begin
                        set_scratch[k] = set_store[j];
                        j++;
                    end
                    k++;
                end
                while (i < mid)
                begin
                    set_scratch[k] = set_store[i];
                    i++;
                    k++;
                end
                while (j < hi)
                begin
                    set_scratch[k] = set_store[j];
                    j++;
                    k++;
                end
                for (k = lo; k < hi; k++)
                    set_store[k] = set_scratch[k];
            end
        end
        for (k = 0; k < set_fill; k++)
            expected_sorted.push_back('{set_store[k], k == set_fill - 1});
        set_fill = 0;
    endtask

    // Store one accepted element; a last flag or a full store closes the set.
    task automatic load_element(logic signed [DATA_W-1:0] value, logic last);
        set_store[set_fill] = value;
        set_fill++;
        if (last || set_fill == DEPTH)
            sort_and_queue();
    endtask

    task automatic add_load(logic signed [DATA_W-1:0] value, logic last, bit hold = 1'b0);
        pending_loads.push_back('{value, last, hold});
    endtask

    // Mix extremes, a narrow band that forces ties, and full-range values.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 4))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                3: return -1;
                default: return 1;
            endcase
        end
        else if (r < 25)
            return $signed($urandom_range(0, 8)) - 4;
        return $urandom;
    endfunction

    // Driver: present pending loads on the item channel, stall the result channel.
    always @(posedge clk or negedge rst_n)
    begin
        bit fire;
        bit calm;
        bit present;
        if (!rst_n)
        begin
            items_ch.valid   <= 1'b0;
            items_ch.value   <= '0;
            items_ch.last_in <= 1'b0;
            sorted_ch.ready  <= 1'b0;
        end
        else
        begin
            fire = items_ch.valid && items_ch.ready;
            if (fire)
            begin
                void'(pending_loads.pop_front());
                loads_accepted++;
            end
            calm = loads_accepted >= CALM_FROM && loads_accepted < CALM_TO;

            // Keep an offered transaction up until it is taken. A held load waits
            // for the previous set to drain completely; skip the acceptance edge,
            // since the outstanding count is registered and catches up in the following cycle.
            if (items_ch.valid && !fire)
                present = 1'b1;
            else if (pending_loads.size() == 0)
                present = 1'b0;
            else if (pending_loads[0].hold && (fire || results_outstanding != 0))
                present = 1'b0;
            else
                present = calm || $urandom_range(0, 99) >= 35;

            items_ch.valid <= present;
            if (present)
            begin
                items_ch.value   <= pending_loads[0].value;
                items_ch.last_in <= pending_loads[0].last;
            end
            sorted_ch.ready <= calm || $urandom_range(0, 99) >= 35;
        end
    end

    // Monitor: check results first, then predict from the load taken at this edge.
    always @(posedge clk)
    begin
        sorted_t exp_item;
        if (rst_n)
        begin
            if (sorted_ch.valid && sorted_ch.ready)
            begin
                if (expected_sorted.size() == 0)
                begin
                    $display("%0t: unexpected result value=%0d last=%0b", $time,
                             sorted_ch.sorted_value, sorted_ch.last_out);
                    mismatches++;
                end
                else
                begin
                    exp_item = expected_sorted.pop_front();
                    if (sorted_ch.sorted_value !== exp_item.value)
                    begin
                        $display("%0t: sorted_value expected %0d actual %0d", $time,
                                 exp_item.value, sorted_ch.sorted_value);
                        mismatches++;
                    end
                    if (sorted_ch.last_out !== exp_item.last)
                    begin
                        $display("%0t: last_out expected %0b actual %0b", $time,
                                 exp_item.last, sorted_ch.last_out);
                        mismatches++;
                    end
                end
            end
            if (items_ch.valid && items_ch.ready)
                load_element(items_ch.value, items_ch.last_in);
            results_outstanding <= expected_sorted.size();
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Build the stimulus, then wait for the run to drain and report.
    initial
    begin
        int set_idx;
        int set_len;
        int r;
        int n;
        bit close_by_depth;

        // Single element at the negative extreme.
        add_load(VAL_MIN, 1'b1);
        // Extremes with an odd set size, so the final run is short.
        add_load(VAL_MAX, 1'b0);
        add_load(VAL_MIN, 1'b0);
        add_load(0, 1'b0);
        add_load(-1, 1'b0);
        add_load(1, 1'b1);
        // Ties; the sender waits for the previous set to drain first.
        add_load(7, 1'b0, 1'b1);
        add_load(-3, 1'b0);
        add_load(7, 1'b0);
        add_load(-3, 1'b0);
        add_load(7, 1'b0);
        add_load(0, 1'b1);
        // Already ascending, power-of-two size.
        add_load(-2, 1'b0);
        add_load(-1, 1'b0);
        add_load(0, 1'b0);
        add_load(1, 1'b1);
        // Descending, eight elements.
        for (n = 0; n < 8; n++)
            add_load(100 - 37 * n, n == 7);

        // Random sets. The first closes by filling the store, the second is also full
        // and may carry last on its 64th element; after that mostly small sets, a few full ones.
        set_idx = 0;
        while (pending_loads.size() < RANDOM_LOADS)
        begin
            r = $urandom_range(0, 99);
            close_by_depth = 1'b0;
            if (set_idx == 0)
            begin
                set_len        = DEPTH;
                close_by_depth = 1'b1;
            end
            else if (set_idx == 1 || r < 6)
            begin
                set_len        = DEPTH;
                close_by_depth = $urandom_range(0, 1);
            end
            else if (r < 20)
                set_len = $urandom_range(17, DEPTH - 1);
            else
                set_len = $urandom_range(1, 16);
            for (n = 0; n < set_len; n++)
                add_load(pick_value(), (n == set_len - 1) && !close_by_depth,
                         (n == 0) && ($urandom_range(0, 7) == 0));
            set_idx++;
        end

        wait (rst_n === 1'b1);
        while (pending_loads.size() != 0 || items_ch.valid)
            @(negedge clk);
        @(negedge clk);
        while (results_outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_sorted.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_sorted.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
